### hdl/rrl_pkg.sv
// Package for the ranging responder link controller.
// Holds packet type codes, event codes, register indexes and the phase type.
// No dependencies.
`default_nettype none

package rrl_pkg;

  // Packet type codes
  localparam logic [7:0] TYP_CONN_REQ  = 8'h05;
  localparam logic [7:0] TYP_CONN_ACK  = 8'h06;
  localparam logic [7:0] TYP_PING      = 8'h01;
  localparam logic [7:0] TYP_PONG      = 8'h02;
  localparam logic [7:0] TYP_START     = 8'h10;
  localparam logic [7:0] TYP_START_ACK = 8'h11;
  localparam logic [7:0] TYP_STOP      = 8'h20;
  localparam logic [7:0] TYP_STOP_ACK  = 8'h21;
  localparam logic [7:0] TYP_TELEM     = 8'hAB;
  localparam logic [7:0] TYP_TELEM_REQ = 8'hAC;

  // Event codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PKT   = 2'd1;
  localparam logic [1:0] ACT_RANGE = 2'd2;

  // Reported link modes
  localparam logic [1:0] MODE_SEEK  = 2'd0;
  localparam logic [1:0] MODE_LINK  = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SEEK_PERIOD = 3'd0;
  localparam logic [2:0] REG_ACK_WINDOW  = 3'd1;
  localparam logic [2:0] REG_SILENCE     = 3'd2;
  localparam logic [2:0] REG_TELEM_WIN   = 3'd3;
  localparam logic [2:0] REG_STOP_WIN    = 3'd4;
  localparam logic [2:0] REG_MISS_LIMIT  = 3'd5;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;
  localparam logic [3:0]  MISS_MAX  = 4'hF;

  // Protocol phase, one-hot
  typedef enum logic [5:0] {
    PH_SEEK  = 6'b000001,
    PH_ACKW  = 6'b000010,
    PH_LINK  = 6'b000100,
    PH_RANG  = 6'b001000,
    PH_TELW  = 6'b010000,
    PH_STOPW = 6'b100000
  } phase_t;

endpackage : rrl_pkg

`default_nettype wire

### hdl/ranging_responder_link_fsm.sv
// Ranging responder link controller: seeking, linked and ranging phases.
// The result of an accepted request is registered in the output register.
// One request per cycle unless the output stalls; the phase update is a
// single pass of logic on the phase, timer, sequence and miss registers.
// Reset (rst_n, synchronous): seeking with a request due on the first tick,
// registers at their defaults, output register empty.
`default_nettype none

module ranging_responder_link_fsm (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic        in_pkt_ok,
  input  wire logic [7:0]  in_pkt_type,
  input  wire logic [7:0]  in_pkt_seq,
  input  wire logic        in_range_ok,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_send_valid,
  output logic [7:0]       out_send_type,
  output logic [7:0]       out_send_seq,
  output logic             out_start_ranging,
  output logic [1:0]       out_link_mode,
  output logic             out_link_lost,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import rrl_pkg::*;

  // Configuration registers
  logic [15:0] seek_period_r, ack_window_r, silence_limit_r;
  logic [15:0] telem_window_r, stop_window_r;
  logic [3:0]  miss_limit_r;

  // Protocol state
  phase_t      phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  req_seq_r, req_seq_nxt;
  logic [3:0]  miss_r, miss_nxt;

  // Output register
  logic        out_valid_r;
  logic        send_valid_r, send_valid_nxt;
  logic [7:0]  send_type_r, send_type_nxt;
  logic [7:0]  send_seq_r, send_seq_nxt;
  logic        start_r, start_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        lost_r, lost_nxt;

  logic        in_acc;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [15:0] timer_inc;
  logic [3:0]  miss_inc;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Accept while the output register is empty or draining
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_period_r   <= 16'd500;
      ack_window_r    <= 16'd400;
      silence_limit_r <= 16'd3000;
      telem_window_r  <= 16'd500;
      stop_window_r   <= 16'd30;
      miss_limit_r    <= 4'd5;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEEK_PERIOD: seek_period_r   <= pwdata[15:0];
        REG_ACK_WINDOW:  ack_window_r    <= pwdata[15:0];
        REG_SILENCE:     silence_limit_r <= pwdata[15:0];
        REG_TELEM_WIN:   telem_window_r  <= pwdata[15:0];
        REG_STOP_WIN:    stop_window_r   <= pwdata[15:0];
        REG_MISS_LIMIT:  miss_limit_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    prdata = 32'd0;
    unique case (cfg_idx)
      REG_SEEK_PERIOD: prdata = {16'd0, seek_period_r};
      REG_ACK_WINDOW:  prdata = {16'd0, ack_window_r};
      REG_SILENCE:     prdata = {16'd0, silence_limit_r};
      REG_TELEM_WIN:   prdata = {16'd0, telem_window_r};
      REG_STOP_WIN:    prdata = {16'd0, stop_window_r};
      REG_MISS_LIMIT:  prdata = {28'd0, miss_limit_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Saturating increments
  assign timer_inc = (timer_r != TIMER_MAX) ? timer_r + 16'd1 : timer_r;
  assign miss_inc  = (miss_r != MISS_MAX) ? miss_r + 4'd1 : miss_r;

  // Phase update for one event
  always_comb begin
    phase_nxt      = phase_r;
    timer_nxt      = timer_r;
    req_seq_nxt    = req_seq_r;
    miss_nxt       = miss_r;
    send_valid_nxt = 1'b0;
    send_type_nxt  = 8'd0;
    send_seq_nxt   = 8'd0;
    start_nxt      = 1'b0;
    lost_nxt       = 1'b0;

    if (in_action == ACT_TICK || in_action == ACT_PKT || in_action == ACT_RANGE) begin
      unique case (phase_r)
        PH_LINK: begin
          if (in_action == ACT_TICK) begin
            timer_nxt = timer_inc;
          end
          // drop on silence, else refresh on any good packet
          if (timer_nxt > silence_limit_r) begin
            phase_nxt = PH_SEEK;
            timer_nxt = TIMER_MAX;
            miss_nxt  = 4'd0;
            lost_nxt  = 1'b1;
          end else if (in_action == ACT_PKT && in_pkt_ok) begin
            timer_nxt = 16'd0;
            miss_nxt  = 4'd0;
            if (in_pkt_type == TYP_PING) begin
              send_valid_nxt = 1'b1;
              send_type_nxt  = TYP_PONG;
              send_seq_nxt   = in_pkt_seq;
            end else if (in_pkt_type == TYP_START) begin
              send_valid_nxt = 1'b1;
              send_type_nxt  = TYP_START_ACK;
              send_seq_nxt   = in_pkt_seq;
              phase_nxt      = PH_RANG;
              start_nxt      = 1'b1;
            end
          end
        end
        PH_RANG: begin
          if (in_action == ACT_RANGE) begin
            if (!in_range_ok) begin
              if (miss_inc >= miss_limit_r) begin
                phase_nxt = PH_SEEK;
                timer_nxt = TIMER_MAX;
                miss_nxt  = 4'd0;
                lost_nxt  = 1'b1;
              end else begin
                miss_nxt  = miss_inc;
                start_nxt = 1'b1;
              end
            end else begin
              miss_nxt  = 4'd0;
              phase_nxt = PH_TELW;
              timer_nxt = 16'd0;
            end
          end
        end
        PH_TELW: begin
          if (in_action == ACT_TICK) begin
            timer_nxt = timer_inc;
            if (timer_inc >= telem_window_r) begin
              phase_nxt = PH_STOPW;
              timer_nxt = 16'd0;
            end
          end else if (in_action == ACT_PKT) begin
            if (in_pkt_ok && in_pkt_type == TYP_TELEM_REQ) begin
              send_valid_nxt = 1'b1;
              send_type_nxt  = TYP_TELEM;
            end
            phase_nxt = PH_STOPW;
            timer_nxt = 16'd0;
          end
        end
        PH_STOPW: begin
          if (in_action == ACT_TICK) begin
            timer_nxt = timer_inc;
            if (timer_inc >= stop_window_r) begin
              phase_nxt = PH_RANG;
              start_nxt = 1'b1;
            end
          end else if (in_action == ACT_PKT) begin
            if (in_pkt_ok && in_pkt_type == TYP_STOP) begin
              send_valid_nxt = 1'b1;
              send_type_nxt  = TYP_STOP_ACK;
              send_seq_nxt   = in_pkt_seq;
              phase_nxt      = PH_LINK;
              timer_nxt      = 16'd0;
              miss_nxt       = 4'd0;
            end else begin
              phase_nxt = PH_RANG;
              start_nxt = 1'b1;
            end
          end
        end
        PH_ACKW: begin
          if (in_action == ACT_TICK) begin
            timer_nxt = timer_inc;
            // window over: fall back to seeking, maybe resend on this tick
            if (timer_inc >= ack_window_r) begin
              phase_nxt = PH_SEEK;
              if (timer_inc >= seek_period_r) begin
                send_valid_nxt = 1'b1;
                send_type_nxt  = TYP_CONN_REQ;
                send_seq_nxt   = req_seq_r;
                req_seq_nxt    = req_seq_r + 8'd1;
                timer_nxt      = 16'd0;
                phase_nxt      = PH_ACKW;
              end
            end
          end else if (in_action == ACT_PKT) begin
            if (in_pkt_ok && in_pkt_type == TYP_CONN_ACK) begin
              phase_nxt = PH_LINK;
              timer_nxt = 16'd0;
              miss_nxt  = 4'd0;
            end else begin
              phase_nxt = PH_SEEK;
            end
          end
        end
        default: begin
          // seeking idle; unknown codes land here too
          phase_nxt = PH_SEEK;
          if (in_action == ACT_TICK) begin
            timer_nxt = timer_inc;
            if (timer_inc >= seek_period_r) begin
              send_valid_nxt = 1'b1;
              send_type_nxt  = TYP_CONN_REQ;
              send_seq_nxt   = req_seq_r;
              req_seq_nxt    = req_seq_r + 8'd1;
              timer_nxt      = 16'd0;
              phase_nxt      = PH_ACKW;
            end
          end
        end
      endcase
    end else begin
      // unused event code: normalize an unknown phase only
      if (phase_r != PH_ACKW && phase_r != PH_LINK && phase_r != PH_RANG &&
          phase_r != PH_TELW && phase_r != PH_STOPW) begin
        phase_nxt = PH_SEEK;
      end
    end

    // Report mode after the event
    if (phase_nxt == PH_LINK) begin
      mode_nxt = MODE_LINK;
    end else if (phase_nxt == PH_RANG || phase_nxt == PH_TELW || phase_nxt == PH_STOPW) begin
      mode_nxt = MODE_RANGE;
    end else begin
      mode_nxt = MODE_SEEK;
    end
  end

  // Advance protocol state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEEK;
      timer_r   <= TIMER_MAX;
      req_seq_r <= 8'd0;
      miss_r    <= 4'd0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      req_seq_r <= req_seq_nxt;
      miss_r    <= miss_nxt;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      send_valid_r <= send_valid_nxt;
      send_type_r  <= send_type_nxt;
      send_seq_r   <= send_seq_nxt;
      start_r      <= start_nxt;
      mode_r       <= mode_nxt;
      lost_r       <= lost_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_valid    = send_valid_r;
  assign out_send_type     = send_type_r;
  assign out_send_seq      = send_seq_r;
  assign out_start_ranging = start_r;
  assign out_link_mode     = mode_r;
  assign out_link_lost     = lost_r;

endmodule : ranging_responder_link_fsm

`default_nettype wire
